// File: design/pfbde_pkg.sv
package pfbde_pkg;

   localparam int DEF_NUM_COLUMNS = 128;
   localparam int DEF_NUM_PAGES = 8;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_SPAN = 3'd1,
      CMD_BYTE_WR = 3'd2,
      CMD_BYTE_RD = 3'd3,
      CMD_CIRCLE = 3'd4,
      CMD_RECT = 3'd5,
      CMD_CLR_AREA = 3'd6,
      CMD_CLR_ALL = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [2:0] page_sel;
      logic [7:0] value;
      logic [3:0] span_len;
      logic [6:0] radius;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] done_cmd;
   } rsp_type;

   // one store access: merge data under mask at a byte address
   typedef struct packed {
      logic       valid;
      logic       read;
      logic [4:0] page;
      logic [7:0] col;
      logic [7:0] data;
      logic [7:0] mask;
   } mem_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SPAN_HI,
      ST_CIRC_PLOT,
      ST_CIRC_STEP,
      ST_RECT_H,
      ST_RECT_V,
      ST_AREA,
      ST_CLR_ALL,
      ST_WAIT,
      ST_RESP
   } state_type;

endpackage

// File: design/page_frame_buffer_draw_engine.sv
// Circles use the midpoint loop, plotting each octant point of a step in turn; rectangles,
// areas and clear all are drawn pixel by pixel or byte by byte through the store.
// Throughput: one command at a time; every pixel is a read-modify-write through
// the single store port, which sets the rate.
// Reset: synchronous; clears the sequencer. The store keeps its contents until
// cleared by a clear-all command.
module page_frame_buffer_draw_engine #(
   parameter int NUM_COLUMNS = pfbde_pkg::DEF_NUM_COLUMNS,
   parameter int NUM_PAGES = pfbde_pkg::DEF_NUM_PAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfbde_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfbde_pkg::rsp_type  rsp_data
);

   localparam int NUM_ROWS = NUM_PAGES * 8;

   pfbde_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   pfbde_pkg::req_type   req_ff;
   pfbde_pkg::mem_op_type op;
   logic       store_busy;
   logic [7:0] store_rd;

   logic [8:0]  i_ff, i_in;
   logic [8:0]  j_ff, j_in;
   logic [2:0]  oct_ff, oct_in;
   logic        second_ff, second_in;
   logic signed [9:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [10:0] err_ff, err_in;
   logic [7:0]  rd_ff, rd_in;
   logic        ld;

   // shared plot unit: a new coordinate pair is taken only once the store is done with the last
   logic [7:0] px, py;
   logic       pon;
   logic       plot;

   pfbde_store #(.NUM_COLUMNS(NUM_COLUMNS), .NUM_PAGES(NUM_PAGES)) u_store (
      .clock(clock), .op(op), .busy(store_busy), .rd_data(store_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfbde_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ret_ff <= ret_in;
      i_ff <= i_in;
      j_ff <= j_in;
      oct_ff <= oct_in;
      second_ff <= second_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      err_ff <= err_in;
      rd_ff <= rd_in;
      if (ld) begin
         req_ff <= req_data;
      end
   end

   logic [15:0] field;
   logic [15:0] smask, sdata;
   logic [3:0]  slen;
   logic signed [9:0] ox, oy, sx, sy;

   always_comb begin
      slen = (req_ff.span_len > 4'd8) ? 4'd8 : req_ff.span_len;
      field = 16'((17'd1 << slen) - 17'd1);
      smask = field << req_ff.y_pos[2:0];
      sdata = (16'(req_ff.value) & field) << req_ff.y_pos[2:0];
      case (oct_ff[1:0])
         2'd0: begin ox = cx_ff; oy = cy_ff; end
         2'd1: begin ox = cy_ff; oy = cx_ff; end
         2'd2: begin ox = -cx_ff; oy = cy_ff; end
         default: begin ox = -cy_ff; oy = cx_ff; end
      endcase
      sx = ox;
      sy = oy;
      if (oct_ff[2]) begin
         sy = -oy;
         if (oct_ff[1:0] == 2'd0 || oct_ff[1:0] == 2'd1) begin
            sx = ox;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      i_in = i_ff;
      j_in = j_ff;
      oct_in = oct_ff;
      second_in = second_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      err_in = err_ff;
      rd_in = rd_ff;
      ld = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      op = '0;
      plot = 1'b0;
      px = '0;
      py = '0;
      pon = 1'b1;
      case (state_ff)
         pfbde_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ld = 1'b1;
               state_in = pfbde_pkg::ST_DISPATCH;
            end
         end
         pfbde_pkg::ST_DISPATCH: begin
            rd_in = '0;
            ret_in = pfbde_pkg::ST_RESP;
            state_in = pfbde_pkg::ST_WAIT;
            case (pfbde_pkg::cmd_type'(req_ff.cmd))
               pfbde_pkg::CMD_PIXEL: begin
                  plot = 1'b1;
                  px = req_ff.x_pos;
                  py = req_ff.y_pos;
                  pon = req_ff.value != 8'd0;
               end
               pfbde_pkg::CMD_SPAN: begin
                  op.valid = slen != 4'd0;
                  op.page = 5'(req_ff.y_pos[7:3]);
                  op.col = req_ff.x_pos;
                  op.data = sdata[7:0];
                  op.mask = smask[7:0];
                  ret_in = pfbde_pkg::ST_SPAN_HI;
               end
               pfbde_pkg::CMD_BYTE_WR: begin
                  op.valid = 1'b1;
                  op.page = 5'(req_ff.page_sel);
                  op.col = req_ff.x_pos;
                  op.data = req_ff.value;
                  op.mask = 8'hff;
               end
               pfbde_pkg::CMD_BYTE_RD: begin
                  op.valid = 1'b1;
                  op.read = 1'b1;
                  op.page = 5'(req_ff.page_sel);
                  op.col = req_ff.x_pos;
               end
               pfbde_pkg::CMD_CIRCLE: begin
                  cx_in = 10'(req_ff.radius);
                  cy_in = '0;
                  err_in = 11'sd1 - 11'(req_ff.radius);
                  oct_in = '0;
                  state_in = pfbde_pkg::ST_CIRC_PLOT;
               end
               pfbde_pkg::CMD_RECT: begin
                  i_in = 9'(req_ff.x_pos);
                  second_in = 1'b0;
                  state_in = pfbde_pkg::ST_RECT_H;
               end
               pfbde_pkg::CMD_CLR_AREA: begin
                  i_in = 9'(req_ff.x_pos);
                  j_in = 9'(req_ff.y_pos);
                  state_in = (req_ff.y_end < req_ff.y_pos) ? pfbde_pkg::ST_RESP
                                                           : pfbde_pkg::ST_AREA;
               end
               default: begin
                  i_in = '0;
                  j_in = '0;
                  state_in = pfbde_pkg::ST_CLR_ALL;
               end
            endcase
         end
         pfbde_pkg::ST_SPAN_HI: begin
            op.valid = (slen != 4'd0) && (smask[15:8] != 8'd0);
            op.page = 5'(req_ff.y_pos[7:3]) + 5'd1;
            op.col = req_ff.x_pos;
            op.data = sdata[15:8];
            op.mask = smask[15:8];
            if (req_ff.y_pos[7:3] > 5'd30) op.valid = 1'b0;
            ret_in = pfbde_pkg::ST_RESP;
            state_in = pfbde_pkg::ST_WAIT;
         end
         pfbde_pkg::ST_CIRC_PLOT: begin
            if (cx_ff < cy_ff) begin
               state_in = pfbde_pkg::ST_RESP;
            end else begin
               plot = 1'b1;
               px = req_ff.x_pos + sx[7:0];
               py = req_ff.y_pos + sy[7:0];
               oct_in = oct_ff + 3'd1;
               ret_in = (oct_ff == 3'd7) ? pfbde_pkg::ST_CIRC_STEP : pfbde_pkg::ST_CIRC_PLOT;
               state_in = pfbde_pkg::ST_WAIT;
            end
         end
         pfbde_pkg::ST_CIRC_STEP: begin
            cy_in = cy_ff + 10'sd1;
            if (err_ff < 0) begin
               err_in = err_ff + 11'(2 * (cy_ff + 10'sd1) + 1);
            end else begin
               cx_in = cx_ff - 10'sd1;
               err_in = err_ff + 11'(2 * ((cy_ff + 10'sd1) - (cx_ff - 10'sd1) + 1));
            end
            state_in = pfbde_pkg::ST_CIRC_PLOT;
         end
         pfbde_pkg::ST_RECT_H: begin
            if (i_ff > 9'(req_ff.x_end) || i_ff > 9'd255) begin
               i_in = 9'(req_ff.y_pos);
               second_in = 1'b0;
               state_in = pfbde_pkg::ST_RECT_V;
            end else begin
               plot = 1'b1;
               px = i_ff[7:0];
               py = second_ff ? req_ff.y_end : req_ff.y_pos;
               second_in = !second_ff;
               if (second_ff) i_in = i_ff + 9'd1;
               ret_in = pfbde_pkg::ST_RECT_H;
               state_in = pfbde_pkg::ST_WAIT;
            end
         end
         pfbde_pkg::ST_RECT_V: begin
            if (i_ff > 9'(req_ff.y_end) || i_ff > 9'd255) begin
               state_in = pfbde_pkg::ST_RESP;
            end else begin
               plot = 1'b1;
               px = second_ff ? req_ff.x_end : req_ff.x_pos;
               py = i_ff[7:0];
               second_in = !second_ff;
               if (second_ff) i_in = i_ff + 9'd1;
               ret_in = pfbde_pkg::ST_RECT_V;
               state_in = pfbde_pkg::ST_WAIT;
            end
         end
         pfbde_pkg::ST_AREA: begin
            if (i_ff > 9'(req_ff.x_end) || i_ff > 9'd255) begin
               state_in = pfbde_pkg::ST_RESP;
            end else begin
               plot = 1'b1;
               pon = 1'b0;
               px = i_ff[7:0];
               py = j_ff[7:0];
               if (j_ff >= 9'(req_ff.y_end) || j_ff >= 9'd255) begin
                  j_in = 9'(req_ff.y_pos);
                  i_in = i_ff + 9'd1;
               end else begin
                  j_in = j_ff + 9'd1;
               end
               ret_in = pfbde_pkg::ST_AREA;
               state_in = pfbde_pkg::ST_WAIT;
            end
         end
         pfbde_pkg::ST_CLR_ALL: begin
            op.valid = 1'b1;
            op.page = j_ff[4:0];
            op.col = i_ff[7:0];
            op.mask = 8'hff;
            if (32'(i_ff) >= NUM_COLUMNS - 1) begin
               i_in = '0;
               j_in = j_ff + 9'd1;
               ret_in = (32'(j_ff) >= NUM_PAGES - 1) ? pfbde_pkg::ST_RESP
                                                     : pfbde_pkg::ST_CLR_ALL;
            end else begin
               i_in = i_ff + 9'd1;
               ret_in = pfbde_pkg::ST_CLR_ALL;
            end
            state_in = pfbde_pkg::ST_WAIT;
         end
         pfbde_pkg::ST_WAIT: begin
            if (!store_busy) begin
               if (pfbde_pkg::cmd_type'(req_ff.cmd) == pfbde_pkg::CMD_BYTE_RD) begin
                  rd_in = (32'(req_ff.page_sel) < NUM_PAGES
                           && 32'(req_ff.x_pos) < NUM_COLUMNS) ? store_rd : 8'd0;
               end
               state_in = ret_ff;
            end
         end
         pfbde_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = pfbde_pkg::ST_IDLE;
         end
         default: state_in = pfbde_pkg::ST_IDLE;
      endcase
      if (plot) begin
         op.valid = (32'(px) < NUM_COLUMNS) && (32'(py) < NUM_ROWS);
         op.page = py[7:3];
         op.col = px;
         op.data = pon ? 8'hff : 8'h00;
         op.mask = 8'(8'd1 << py[2:0]);
      end
   end

   assign rsp_data.read_data = rd_ff;
   assign rsp_data.done_cmd = req_ff.cmd;

endmodule

// File: design/pfbde_store.sv
module pfbde_store #(
   parameter int NUM_COLUMNS = pfbde_pkg::DEF_NUM_COLUMNS,
   parameter int NUM_PAGES = pfbde_pkg::DEF_NUM_PAGES
) (
   input  logic                  clock,
   input  pfbde_pkg::mem_op_type op,
   output logic                  busy,
   output logic [7:0]            rd_data
);

   localparam int DEPTH = NUM_COLUMNS * NUM_PAGES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];

   // stage 1: read; stage 2: merge and write
   logic          s1_valid_ff;
   logic          s1_write_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [7:0]    s1_data_ff;
   logic [7:0]    s1_mask_ff;
   logic [7:0]    s1_rd_ff;
   logic          in_range;
   logic [AW-1:0] addr;

   assign in_range = (32'(op.page) < NUM_PAGES) && (32'(op.col) < NUM_COLUMNS);
   assign addr = AW'(32'(op.page) * NUM_COLUMNS + 32'(op.col));
   assign busy = s1_valid_ff;

   always_ff @(posedge clock) begin
      s1_valid_ff <= op.valid;
      s1_write_ff <= op.valid && !op.read && in_range;
      s1_addr_ff <= addr;
      s1_data_ff <= op.data;
      s1_mask_ff <= op.mask;
      if (op.valid) begin
         s1_rd_ff <= mem[addr];
      end
      if (s1_write_ff) begin
         mem[s1_addr_ff] <= (s1_rd_ff & ~s1_mask_ff) | (s1_data_ff & s1_mask_ff);
      end
   end

   assign rd_data = s1_rd_ff;

endmodule
